// ----- rtl/ppn_pkg.sv -----
// Shared types and constants of the polygon plane normal block.
// No dependencies; imported by every module of the block.
package ppn_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned Q_DEPTH        = 2;
  localparam int unsigned COORD_W        = 24;
  localparam int unsigned NORM_W         = 16;
  localparam int unsigned TOL_W          = 8;
  localparam int unsigned DIFF_W         = 25;
  localparam int unsigned PROD_W         = 50;
  localparam int unsigned CROSS_W        = 51;
  localparam int unsigned MAG_W          = 31;
  localparam int unsigned SQ_W           = 62;
  localparam int unsigned SUM_W          = 64;
  localparam int unsigned ROOT_W         = 33;
  localparam int unsigned NUM_W          = 47;
  localparam int unsigned QUO_W          = 15;
  localparam int unsigned FRAC_W         = 14;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;
  localparam logic [QUO_W-1:0] UNIT_ONE  = 15'd16384;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FEW  = 2'd1,
    STAT_DIFF = 2'd2,
    STAT_OVF  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } vec_t;

endpackage

// ----- rtl/ppn_front.sv -----
// Front end: accepts vertices, writes the point store, counts them and
// queues one job per polygon. Depends on ppn_pkg.
module ppn_front import ppn_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned CW         = $clog2(MAX_POINTS + 1),
  parameter int unsigned AW         = $clog2(MAX_POINTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  point_t        pt_i,
  input  logic          last_i,
  output logic          push_o,
  output logic [CW:0]   push_data_o,
  input  logic          q_ready_i,
  input  logic          done_i,
  input  logic [AW-1:0] rd_addr_i,
  output point_t        rd_data_o
);

  point_t        mem [MAX_POINTS];
  point_t        rd_q;
  logic [CW-1:0] count_q;
  logic          ovf_q;
  logic          lock_q;
  logic          accept;
  logic          full;

  assign in_stall_o  = lock_q || !q_ready_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign full        = (count_q == CW'(MAX_POINTS));
  assign push_o      = accept && last_i;
  assign push_data_o = {(full ? count_q : count_q + CW'(1)), ovf_q | full};
  assign rd_data_o   = rd_q;

  always_ff @(posedge clk_i) begin
    if (accept && !full) begin
      mem[count_q[AW-1:0]] <= pt_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      lock_q  <= 1'b0;
    end else begin
      if (accept) begin
        if (last_i) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
          lock_q  <= 1'b1;
        end else if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end else if (done_i) begin
        lock_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/ppn_fifo.sv -----
// Small job queue between front and back end.
// Depends on ppn_pkg for its default depth.
module ppn_fifo import ppn_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = Q_DEPTH,
  parameter int unsigned PW    = $clog2(DEPTH)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         ready_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0]  ent_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign ready_o = (cnt_q != (PW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = ent_q[rp_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/ppn_norm.sv -----
// Multi-cycle unit normal of a point triple: one multiplier for the cross
// product, another for the squares, iterative square root and divider. Depends on ppn_pkg.
module ppn_norm import ppn_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  point_t p1_i,
  input  point_t p2_i,
  input  point_t p3_i,
  output logic   done_o,
  output vec_t   n_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_DINIT = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;

  logic [3:0]                state_q;
  logic signed [DIFF_W-1:0]  ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic                      coin_q;
  logic [4:0]                cnt_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [CROSS_W-1:0] cr_q [3];
  logic [CROSS_W-1:0]        m_q [3];
  logic                      sgn_q [3];
  logic [SQ_W-1:0]           sq_q;
  logic [SUM_W-1:0]          sum_q, x_q, r_q, bit_q;
  logic [ROOT_W-1:0]         len_q;
  logic [NUM_W-1:0]          rem_q, dsh_q;
  logic [QUO_W-1:0]          quo_q;
  logic [1:0]                k_q;
  logic signed [NORM_W-1:0]  n_q [3];
  logic                      done_q;

  logic signed [DIFF_W-1:0]  ma, mb;
  logic signed [CROSS_W-1:0] pext;
  logic [SUM_W-1:0]          sq_t, r_nx;
  logic                      sq_ge;
  logic                      hi, has30, all_zero, dge;
  logic [QUO_W-1:0]          q_fin, q_clip;

  always_comb begin
    unique case (cnt_q[2:0])
      3'd0:    begin ma = vy_q; mb = uz_q; end
      3'd1:    begin ma = vz_q; mb = uy_q; end
      3'd2:    begin ma = vz_q; mb = ux_q; end
      3'd3:    begin ma = vx_q; mb = uz_q; end
      3'd4:    begin ma = vx_q; mb = uy_q; end
      3'd5:    begin ma = vy_q; mb = ux_q; end
      default: begin ma = '0;   mb = '0;   end
    endcase
  end

  assign pext     = CROSS_W'(prod_q);
  assign hi       = (|m_q[0][CROSS_W-1:MAG_W]) || (|m_q[1][CROSS_W-1:MAG_W]) ||
                    (|m_q[2][CROSS_W-1:MAG_W]);
  assign has30    = m_q[0][MAG_W-1] || m_q[1][MAG_W-1] || m_q[2][MAG_W-1];
  assign all_zero = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
  assign sq_t     = r_q + bit_q;
  assign sq_ge    = (x_q >= sq_t);
  assign r_nx     = sq_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
  assign dge      = (rem_q >= dsh_q);
  assign q_fin    = {quo_q[QUO_W-2:0], dge};
  assign q_clip   = (q_fin > UNIT_ONE) ? UNIT_ONE : q_fin;
  assign done_o   = done_q;
  assign n_o      = '{x: n_q[0], y: n_q[1], z: n_q[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_MUL;
            cnt_q   <= '0;
          end
        end
        S_MUL: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd6) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (coin_q || all_zero) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end else begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (!hi && has30) begin
            state_q <= S_SQ;
            cnt_q   <= '0;
          end
        end
        S_SQ: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd3) begin
            state_q <= S_SQRT;
            cnt_q   <= '0;
          end
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= S_DINIT;
            k_q     <= '0;
          end
        end
        S_DINIT: begin
          state_q <= S_DIV;
          cnt_q   <= '0;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(QUO_W - 1)) begin
            k_q <= k_q + 2'd1;
            if (k_q == 2'd2) begin
              state_q <= S_IDLE;
              done_q  <= 1'b1;
            end else begin
              state_q <= S_DINIT;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ux_q   <= DIFF_W'(p1_i.x) - DIFF_W'(p2_i.x);
          uy_q   <= DIFF_W'(p1_i.y) - DIFF_W'(p2_i.y);
          uz_q   <= DIFF_W'(p1_i.z) - DIFF_W'(p2_i.z);
          vx_q   <= DIFF_W'(p3_i.x) - DIFF_W'(p2_i.x);
          vy_q   <= DIFF_W'(p3_i.y) - DIFF_W'(p2_i.y);
          vz_q   <= DIFF_W'(p3_i.z) - DIFF_W'(p2_i.z);
          coin_q <= (p1_i == p2_i) || (p1_i == p3_i) || (p2_i == p3_i);
        end
      end
      S_MUL: begin
        prod_q <= ma * mb;
        unique case (cnt_q[2:0])
          3'd1:    cr_q[0] <= pext;
          3'd2:    cr_q[0] <= cr_q[0] - pext;
          3'd3:    cr_q[1] <= pext;
          3'd4:    cr_q[1] <= cr_q[1] - pext;
          3'd5:    cr_q[2] <= pext;
          3'd6:    cr_q[2] <= cr_q[2] - pext;
          default: ;
        endcase
      end
      S_CHK: begin
        for (int k = 0; k < 3; k++) begin
          sgn_q[k] <= cr_q[k][CROSS_W-1];
          m_q[k]   <= cr_q[k][CROSS_W-1] ? CROSS_W'(-cr_q[k]) : CROSS_W'(cr_q[k]);
          if (coin_q || all_zero) begin
            n_q[k] <= '0;
          end
        end
      end
      S_NORM: begin
        sum_q <= '0;
        for (int k = 0; k < 3; k++) begin
          if (hi) begin
            m_q[k] <= m_q[k] >> 1;
          end else if (!has30) begin
            m_q[k] <= m_q[k] << 1;
          end
        end
      end
      S_SQ: begin
        if (cnt_q != 5'd3) begin
          sq_q   <= SQ_W'(m_q[0][MAG_W-1:0] * m_q[0][MAG_W-1:0]);
          m_q[0] <= m_q[1];
          m_q[1] <= m_q[2];
          m_q[2] <= m_q[0];
        end
        if (cnt_q == 5'd1 || cnt_q == 5'd2) begin
          sum_q <= sum_q + SUM_W'(sq_q);
        end
        if (cnt_q == 5'd3) begin
          x_q   <= sum_q + SUM_W'(sq_q);
          r_q   <= '0;
          bit_q <= SUM_W'(1) << (SUM_W - 2);
        end
      end
      S_SQRT: begin
        if (sq_ge) begin
          x_q <= x_q - sq_t;
        end
        r_q   <= r_nx;
        bit_q <= bit_q >> 2;
        if (cnt_q == 5'd31) begin
          len_q <= r_nx[ROOT_W-1:0];
        end
      end
      S_DINIT: begin
        rem_q <= (NUM_W'(m_q[0][MAG_W-1:0]) << FRAC_W) + NUM_W'(len_q >> 1);
        dsh_q <= NUM_W'(len_q) << (QUO_W - 1);
        quo_q <= '0;
      end
      S_DIV: begin
        if (dge) begin
          rem_q <= rem_q - dsh_q;
        end
        dsh_q <= dsh_q >> 1;
        quo_q <= q_fin;
        if (cnt_q == 5'(QUO_W - 1)) begin
          n_q[0]   <= n_q[1];
          n_q[1]   <= n_q[2];
          n_q[2]   <= sgn_q[0] ? -NORM_W'(q_clip) : NORM_W'(q_clip);
          m_q[0]   <= m_q[1];
          m_q[1]   <= m_q[2];
          m_q[2]   <= m_q[0];
          sgn_q[0] <= sgn_q[1];
          sgn_q[1] <= sgn_q[2];
          sgn_q[2] <= sgn_q[0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/ppn_back.sv -----
// Back end: walks the stored triples of one polygon through the normal
// unit, compares against the sample and holds the result. Depends on ppn_pkg.
module ppn_back import ppn_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned CW         = $clog2(MAX_POINTS + 1),
  parameter int unsigned AW         = $clog2(MAX_POINTS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  logic [CW:0]      job_i,
  output logic             job_pop_o,
  output logic [AW-1:0]    rd_addr_o,
  input  point_t           rd_data_i,
  input  logic [TOL_W-1:0] tol_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output vec_t             out_vec_o,
  output status_e          out_status_o,
  output logic             done_o
);

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_RA   = 4'd1;
  localparam logic [3:0] B_RB   = 4'd2;
  localparam logic [3:0] B_RC   = 4'd3;
  localparam logic [3:0] B_RD   = 4'd4;
  localparam logic [3:0] B_GO   = 4'd5;
  localparam logic [3:0] B_WAIT = 4'd6;
  localparam logic [3:0] B_RN   = 4'd7;
  localparam logic [3:0] B_SH   = 4'd8;
  localparam logic [3:0] B_EMIT = 4'd9;

  logic [3:0]    state_q;
  logic [CW-1:0] n_q, nxt_q, last_idx;
  logic          phase_q;
  point_t        pa_q, pb_q, pc_q;
  vec_t          smp_q, res_q, out_q;
  status_e       rstat_q, ostat_q;
  logic          out_valid_q;
  logic          nrm_done;
  vec_t          nrm;
  logic          emit, mism;
  logic [CW-1:0] job_cnt;
  logic          job_ovf;

  assign job_cnt      = job_i[CW:1];
  assign job_ovf      = job_i[0];
  assign last_idx     = n_q - CW'(1);
  assign job_pop_o    = (state_q == B_IDLE) && job_valid_i;
  assign emit         = (state_q == B_EMIT) && (!out_valid_q || !out_stall_i);
  assign done_o       = emit;
  assign out_valid_o  = out_valid_q;
  assign out_vec_o    = out_q;
  assign out_status_o = ostat_q;

  function automatic logic far(input logic signed [NORM_W-1:0] a,
                               input logic signed [NORM_W-1:0] b,
                               input logic [TOL_W-1:0] t);
    logic signed [NORM_W:0] d;
    logic [NORM_W:0]        ad;
    d  = (NORM_W+1)'(a) - (NORM_W+1)'(b);
    ad = d[NORM_W] ? (NORM_W+1)'(-d) : (NORM_W+1)'(d);
    return ad > (NORM_W+1)'(t);
  endfunction

  assign mism = far(nrm.x, smp_q.x, tol_i) || far(nrm.y, smp_q.y, tol_i) ||
                far(nrm.z, smp_q.z, tol_i);

  always_comb begin
    unique case (state_q)
      B_RA:    rd_addr_o = last_idx[AW-1:0];
      B_RC:    rd_addr_o = AW'(1);
      B_RN:    rd_addr_o = nxt_q[AW-1:0];
      default: rd_addr_o = '0;
    endcase
  end

  ppn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == B_GO),
    .p1_i    (pa_q),
    .p2_i    (pb_q),
    .p3_i    (pc_q),
    .done_o  (nrm_done),
    .n_o     (nrm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            if (job_ovf || job_cnt <= CW'(3)) begin
              state_q <= B_EMIT;
            end else begin
              state_q <= B_RA;
            end
          end
        end
        B_RA:   state_q <= B_RB;
        B_RB:   state_q <= B_RC;
        B_RC:   state_q <= B_RD;
        B_RD:   state_q <= B_GO;
        B_GO:   state_q <= B_WAIT;
        B_WAIT: begin
          if (nrm_done) begin
            if (!phase_q) begin
              state_q <= B_RN;
            end else if (mism || nxt_q >= n_q) begin
              state_q <= B_EMIT;
            end else begin
              state_q <= B_RN;
            end
          end
        end
        B_RN:   state_q <= B_SH;
        B_SH:   state_q <= B_GO;
        B_EMIT: begin
          if (emit) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q   <= res_q;
      ostat_q <= rstat_q;
    end
    unique case (state_q)
      B_IDLE: begin
        n_q     <= job_cnt;
        phase_q <= 1'b0;
        res_q   <= '0;
        rstat_q <= job_ovf ? STAT_OVF : STAT_FEW;
      end
      B_RB: pa_q <= rd_data_i;
      B_RC: pb_q <= rd_data_i;
      B_RD: pc_q <= rd_data_i;
      B_WAIT: begin
        if (nrm_done) begin
          if (!phase_q) begin
            smp_q   <= nrm;
            phase_q <= 1'b1;
            nxt_q   <= CW'(2);
          end else if (mism) begin
            res_q   <= '0;
            rstat_q <= STAT_DIFF;
          end else begin
            res_q   <= smp_q;
            rstat_q <= STAT_OK;
          end
        end
      end
      B_SH: begin
        pa_q  <= pb_q;
        pb_q  <= pc_q;
        pc_q  <= rd_data_i;
        nxt_q <= nxt_q + CW'(1);
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/polygon_plane_normal_top.sv -----
// Top level of the polygon plane normal block: front end, job queue, back end
// and the tolerance register. Depends on ppn_pkg, ppn_front, ppn_fifo, ppn_back.
//
// Usage: vertices enter on the in channel (valid/stall), one per cycle while
// in_stall_o is low. last_point_i closes a polygon; the front end then stalls
// until that polygon's single result has been loaded into the output register.
// Results leave on the out channel (valid/stall) and are held while out_stall_i
// is high. match_tolerance is written through cfg_valid_i/cfg_ready_o/cfg_data_i
// (always ready) and resets to 1; the user must do so only while the block is idle,
// which the block itself does not enforce.
// Flow: fewer than four points or an overflow gives a result without the
// normal unit. Otherwise each of the N - 1 triples is fetched and started
// and then passes through the normal unit: cross product, normalization,
// squares, square root and three 15-step divisions, plus the check state.
// Vertex loading sustains one vertex per cycle while in_stall_o is low.
// Reset empties the store count, the queue and the output register; the store
// contents are not cleared.
module polygon_plane_normal_top import ppn_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned CW         = $clog2(MAX_POINTS + 1),
  parameter int unsigned AW         = $clog2(MAX_POINTS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  input  logic signed [COORD_W-1:0] z_coord_i,
  input  logic                      last_point_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [NORM_W-1:0]  normal_x_o,
  output logic signed [NORM_W-1:0]  normal_y_o,
  output logic signed [NORM_W-1:0]  normal_z_o,
  output logic [1:0]                status_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [TOL_W-1:0]          cfg_data_i
);

  logic [TOL_W-1:0] tol_q;
  logic             q_push, q_ready, q_valid, q_pop;
  logic [CW:0]      q_wdata, q_rdata;
  logic [AW-1:0]    rd_addr;
  point_t           rd_data;
  logic             back_done;
  vec_t             out_vec;
  status_e          out_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  ppn_front #(.MAX_POINTS(MAX_POINTS), .CW(CW), .AW(AW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pt_i        ('{x: x_coord_i, y: y_coord_i, z: z_coord_i}),
    .last_i      (last_point_i),
    .push_o      (q_push),
    .push_data_o (q_wdata),
    .q_ready_i   (q_ready),
    .done_i      (back_done),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data)
  );

  ppn_fifo #(.W(CW + 1), .DEPTH(Q_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  ppn_back #(.MAX_POINTS(MAX_POINTS), .CW(CW), .AW(AW)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_i        (q_rdata),
    .job_pop_o    (q_pop),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .tol_i        (tol_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_vec_o    (out_vec),
    .out_status_o (out_status),
    .done_o       (back_done)
  );

  assign normal_x_o = out_vec.x;
  assign normal_y_o = out_vec.y;
  assign normal_z_o = out_vec.z;
  assign status_o   = out_status;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |->
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("error result with nonzero normal");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_ready)
    else $error("job pushed into full queue");

  a_locked_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_done |-> in_stall_o)
    else $error("vertex input open while a polygon is being checked");

endmodule

// ----- test/polygon_plane_normal_top_tb.sv -----
// Testbench of polygon_plane_normal_top: random and directed polygons, with an
// in-bench normal predictor and a scoreboard class. Depends on rtl/ppn_pkg.sv
// and the RTL of the block.
module polygon_plane_normal_top_tb;
  import ppn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPTS = MAX_POINTS_DEF;

  class normal_scoreboard;
    int signed     pts_x[NPTS];
    int signed     pts_y[NPTS];
    int signed     pts_z[NPTS];
    int unsigned   npoints;
    bit            overflowed;
    int unsigned   tolerance;
    vec_t          exp_normal[$];
    status_e       exp_status[$];
    int unsigned   errors;
    int unsigned   seen[4];

    function new();
      npoints    = 0;
      overflowed = 0;
      tolerance  = TOL_RESET;
      errors     = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic bit same_pt(int a, int b);
      return pts_x[a] == pts_x[b] && pts_y[a] == pts_y[b] && pts_z[a] == pts_z[b];
    endfunction

    function automatic void tri_normal(int a, int b, int c, output int signed n[3]);
      longint signed   ux, uy, uz, vx, vy, vz;
      longint signed   cr[3];
      longint unsigned m[3], mx, sum, len, q;
      n[0] = 0; n[1] = 0; n[2] = 0;
      if (same_pt(a, b) || same_pt(a, c) || same_pt(b, c)) return;
      ux = longint'(pts_x[a]) - pts_x[b];
      uy = longint'(pts_y[a]) - pts_y[b];
      uz = longint'(pts_z[a]) - pts_z[b];
      vx = longint'(pts_x[c]) - pts_x[b];
      vy = longint'(pts_y[c]) - pts_y[b];
      vz = longint'(pts_z[c]) - pts_z[b];
      cr[0] = vy * uz - vz * uy;
      cr[1] = vz * ux - vx * uz;
      cr[2] = vx * uy - vy * ux;
      mx = 0;
      for (int k = 0; k < 3; k++) begin
        m[k] = cr[k] < 0 ? longint'(-cr[k]) : longint'(cr[k]);
        if (m[k] > mx) mx = m[k];
      end
      if (mx == 0) return;
      while (mx >= (64'd1 << 31)) begin
        for (int k = 0; k < 3; k++) m[k] >>= 1;
        mx >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
        for (int k = 0; k < 3; k++) m[k] <<= 1;
        mx <<= 1;
      end
      sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = isqrt(sum);
      if (len == 0) return;
      for (int k = 0; k < 3; k++) begin
        q = (m[k] * 16384 + len / 2) / len;
        if (q > 16384) q = 16384;
        n[k] = cr[k] < 0 ? -int'(q) : int'(q);
      end
    endfunction

    function automatic void note_vertex(point_t p, bit last);
      int signed smp[3], tst[3], d;
      status_e   st;
      vec_t      v;
      if (npoints < NPTS) begin
        pts_x[npoints] = p.x;
        pts_y[npoints] = p.y;
        pts_z[npoints] = p.z;
        npoints++;
      end else begin
        overflowed = 1;
      end
      if (!last) return;
      st = STAT_OK;
      smp[0] = 0; smp[1] = 0; smp[2] = 0;
      if (overflowed) st = STAT_OVF;
      else if (npoints <= 3) st = STAT_FEW;
      else begin
        tri_normal(npoints - 1, 0, 1, smp);
        for (int i = 1; i + 1 < npoints && st == STAT_OK; i++) begin
          tri_normal(i - 1, i, i + 1, tst);
          for (int k = 0; k < 3; k++) begin
            d = tst[k] - smp[k];
            if (d < 0) d = -d;
            if (d > int'(tolerance)) st = STAT_DIFF;
          end
        end
      end
      if (st != STAT_OK) begin
        smp[0] = 0; smp[1] = 0; smp[2] = 0;
      end
      v.x = smp[0][NORM_W-1:0];
      v.y = smp[1][NORM_W-1:0];
      v.z = smp[2][NORM_W-1:0];
      exp_normal.push_back(v);
      exp_status.push_back(st);
      npoints    = 0;
      overflowed = 0;
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("%0t ns: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    endtask

    task check_result(vec_t v, logic [1:0] st);
      vec_t    ev;
      status_e es;
      if (exp_status.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, status %0d", $realtime, st);
        return;
      end
      ev = exp_normal.pop_front();
      es = exp_status.pop_front();
      seen[es]++;
      if (v.x != ev.x) report("normal_x", v.x, ev.x);
      if (v.y != ev.y) report("normal_y", v.y, ev.y);
      if (v.z != ev.z) report("normal_z", v.z, ev.z);
      if (st != es) report("status", st, es);
    endtask

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [COORD_W-1:0] x_coord_i = '0;
  logic signed [COORD_W-1:0] y_coord_i = '0;
  logic signed [COORD_W-1:0] z_coord_i = '0;
  logic                      last_point_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [NORM_W-1:0]  normal_x_o, normal_y_o, normal_z_o;
  logic [1:0]                status_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [TOL_W-1:0]          cfg_data_i = '0;

  normal_scoreboard sb = new();
  int unsigned      items_sent = 0;
  int unsigned      polys_sent = 0;

  always #2 clk_i = ~clk_i;

  polygon_plane_normal_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .x_coord_i, .y_coord_i, .z_coord_i,
    .last_point_i, .out_valid_o, .out_stall_i, .normal_x_o, .normal_y_o, .normal_z_o,
    .status_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // receiver: random stalls, one quiet stretch and one long hold-off
  initial begin
    int unsigned cyc;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= 1500 && cyc < 1900) out_stall_i <= 1'b1;
      else if (cyc >= 6000 && cyc < 16000) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(99) < 9);
    end
  end

  always @(negedge clk_i) begin
    vec_t v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      v.x = normal_x_o;
      v.y = normal_y_o;
      v.z = normal_z_o;
      sb.check_result(v, status_o);
    end
  end

  int unsigned send_cyc = 0;
  always @(posedge clk_i) send_cyc <= send_cyc + 1;

  task send_vertex(int signed x, int signed y, int signed z, bit last);
    point_t p;
    bit     acc;
    if (!(send_cyc >= 3000 && send_cyc < 9000) && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    p.x = x[COORD_W-1:0];
    p.y = y[COORD_W-1:0];
    p.z = z[COORD_W-1:0];
    in_valid_i   <= 1'b1;
    x_coord_i    <= p.x;
    y_coord_i    <= p.y;
    z_coord_i    <= p.z;
    last_point_i <= last;
    do begin
      @(negedge clk_i);
      acc = !in_stall_o;
      if (acc) sb.note_vertex(p, last);
      @(posedge clk_i);
    end while (!acc);
    items_sent++;
    if (last) polys_sent++;
  endtask

  task write_tolerance(logic [TOL_W-1:0] v);
    bit acc;
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end while (!acc);
    cfg_valid_i  <= 1'b0;
    sb.tolerance  = v;
  endtask

  // convex polygon on a random plane: parabola points in plane coordinates
  task send_planar(int n);
    int signed ox, oy, oz, e1[3], e2[3], s, t, a, b;
    ox = $urandom_range(14000000) - 7000000;
    oy = $urandom_range(14000000) - 7000000;
    oz = $urandom_range(14000000) - 7000000;
    for (int k = 0; k < 3; k++) begin
      e1[k] = $urandom_range(80) - 40;
      e2[k] = $urandom_range(80) - 40;
    end
    s = $urandom_range(1, 200);
    t = $urandom_range(1, 3);
    for (int k = 0; k < n; k++) begin
      a = k * s;
      b = k * k * t;
      send_vertex(ox + a * e1[0] + b * e2[0], oy + a * e1[1] + b * e2[1],
                  oz + a * e1[2] + b * e2[2], k == n - 1);
    end
  endtask

  task send_noise(int n);
    for (int k = 0; k < n; k++)
      send_vertex($urandom, $urandom, $urandom, k == n - 1);
  endtask

  task send_random_polygon();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) send_planar(r < 4 ? $urandom_range(20, 64) : $urandom_range(4, 10));
    else if (r < 82) send_noise($urandom_range(4, 8));
    else if (r < 94) send_noise($urandom_range(1, 3));
    else if (r < 96) send_noise($urandom_range(65, 70));
    else begin
      int signed dx, dy, dz;
      dx = $urandom_range(2000) - 1000;
      dy = $urandom_range(2000) - 1000;
      dz = $urandom_range(2000) - 1000;
      for (int k = 0; k < 5; k++) send_vertex(k * dx, k * dy, k * dz, k == 4);
    end
  endtask

  initial begin
    logic [TOL_W-1:0] tols[5];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_vertex(8388607, 8388607, 8388607, 1);
    send_vertex(-8388608, -8388608, -8388608, 0);
    send_vertex(8388607, -8388608, 0, 0);
    send_vertex(0, 8388607, -8388608, 1);
    send_vertex(0, 0, 0, 0);
    send_vertex(4096, 0, 0, 0);
    send_vertex(4096, 4096, 0, 0);
    send_vertex(0, 4096, 0, 1);
    send_vertex(100, 200, 300, 0);
    send_vertex(100, 200, 300, 0);
    send_vertex(500, -200, 30, 0);
    send_vertex(-40, 90, 7, 1);
    send_vertex(0, 0, 0, 0);
    send_vertex(10, 20, 30, 0);
    send_vertex(20, 40, 60, 0);
    send_vertex(30, 60, 90, 1);
    send_vertex(-8388608, 0, 8388607, 0);
    send_vertex(12345, -54321, 777, 0);
    send_vertex(8388607, 8388607, -8388608, 0);
    send_vertex(-8388608, 0, 8388607, 1);

    tols[0] = 8'd0;
    tols[1] = 8'd255;
    tols[2] = $urandom_range(2, 254);
    tols[3] = TOL_RESET;
    tols[4] = $urandom_range(0, 255);
    foreach (tols[i]) begin
      write_tolerance(tols[i]);
      while (items_sent < 20 + (i + 1) * 126) send_random_polygon();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d vertices in %0d polygons, tolerances 0 to 255.",
             items_sent, polys_sent);
    $display("Results: %0d ok, %0d too few, %0d disagree, %0d overflow.",
             sb.seen[STAT_OK], sb.seen[STAT_FEW], sb.seen[STAT_DIFF], sb.seen[STAT_OVF]);
    if (sb.errors == 0) begin
      $display("polygon_plane_normal_top test passed");
    end else begin
      $display("polygon_plane_normal_top test failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("polygon_plane_normal_top test failed");
    $finish;
  end

endmodule
